/* hdl/kmpt_pkg.sv */
// Shared types and constants for the keyed minimum-priority table.
// Used by the slot cell, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package kmpt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int SUM_W   = 22;
  localparam int LIVE_W  = 7;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_RELEASE  = 3'd1,
    ACT_POP      = 3'd2,
    ACT_PEEK     = 3'd3,
    ACT_CONTAINS = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_ZERO_KEY = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [KEY_W-1:0] entry_key;
    logic [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [KEY_W-1:0]  out_key;
    logic [VAL_W-1:0]  out_value;
    logic [SUM_W-1:0]  total_cost;
    logic [LIVE_W-1:0] live_count;
  } rsp_t;

  // one table slot as it travels along the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

/* hdl/kmpt_cell.sv */
// One slot of the rotating table: holds a slot and takes its neighbor's on shift.
// Depends on kmpt_pkg.
`timescale 1ns / 1ps

module kmpt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kmpt_pkg::cell_ctl_t ctl_i,
  input  kmpt_pkg::slot_t    slot_i,
  output kmpt_pkg::slot_t    slot_o
);
  import kmpt_pkg::*;

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      key_q   <= slot_i.key;
      value_q <= slot_i.value;
    end
  end

  assign slot_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

/* hdl/keyed_min_priority_table.sv */
// Keyed minimum-priority table: top level with the sequencer and the cell chain.
// Depends on kmpt_pkg and kmpt_cell.
`timescale 1ns / 1ps

// The table is a ring of ENTRIES cells that rotates one slot per cycle past
// the sequencer while a scan or write-back pass runs. Insert, release and
// pop take one full rotation to look up the key, the free slot and the lowest
// value, a decide state, and a second rotation to write the chosen slot back.
// Peek, contains and failed actions skip the second rotation. Clear, zero-key
// insert and unused codes skip both rotations. The table is empty after
// reset; no clearing pass is needed.

module keyed_min_priority_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kmpt_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output kmpt_pkg::rsp_t out_data_o
);
  import kmpt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_APPLY  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    OP_SET_VALUE = 2'd0,
    OP_NEW       = 2'd1,
    OP_KILL      = 2'd2
  } op_e;

  state_e state_q, state_d;

  logic [2:0]       act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] cnt_q;

  // lookup results collected during the scan
  logic             hit_q, free_q, min_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q, min_idx_q;
  logic [VAL_W-1:0] hit_val_q, min_val_q;
  logic [KEY_W-1:0] min_key_q;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] tgt_q, tgt_d;
  op_e              op_q, op_d;

  logic [1:0]       res_status_q, res_status_d;
  logic             res_found_q, res_found_d;
  logic [KEY_W-1:0] res_key_q, res_key_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;

  logic             out_valid_q;
  rsp_t             out_data_q;

  slot_t            chain[ENTRIES];
  slot_t            tail, wb;
  cell_ctl_t        cell_ctl;
  logic             accept, last, out_free;
  logic [CNT_W+LIVE_W-1:0] count_ext;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign last      = (cnt_q == IDX_W'(ENTRIES - 1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign tail      = chain[0];
  assign count_ext = {{LIVE_W{1'b0}}, count_q};

  assign cell_ctl.shift = (state_q == S_SCAN) || (state_q == S_APPLY);
  assign cell_ctl.clear = accept && (in_data_i.action == ACT_CLEAR);

  // write-back into the head of the ring; only the target slot changes
  always_comb begin
    wb = tail;
    if (state_q == S_APPLY && cnt_q == tgt_q) begin
      unique case (op_q)
        OP_SET_VALUE: wb.value = val_q;
        OP_NEW:       wb = '{valid: 1'b1, key: key_q, value: val_q};
        OP_KILL:      wb.valid = 1'b0;
        default:      wb = tail;
      endcase
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    slot_t nxt;
    if (i == ENTRIES - 1) begin : g_head
      assign nxt = wb;
    end else begin : g_body
      assign nxt = chain[i+1];
    end
    kmpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .slot_i (nxt),
      .slot_o (chain[i])
    );
  end

  // decision after the scan, and the fast paths at accept
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    count_d      = count_q;
    tgt_d        = tgt_q;
    op_d         = op_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_key_d    = '0;
          res_val_d    = '0;
          state_d      = S_EMIT;
          priority if (in_data_i.action == ACT_CLEAR) begin
            sum_d   = '0;
            count_d = '0;
          end else if (in_data_i.action == ACT_INSERT && in_data_i.entry_key == '0) begin
            res_status_d = ST_ZERO_KEY;
          end else if (in_data_i.action > ACT_CLEAR) begin
            // unused code: no change
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_EMIT;
        unique case (act_q)
          ACT_INSERT: begin
            if (hit_q) begin
              sum_d       = sum_q - SUM_W'(hit_val_q) + SUM_W'(val_q);
              res_found_d = 1'b1;
              op_d        = OP_SET_VALUE;
              tgt_d       = hit_idx_q;
              state_d     = S_APPLY;
            end else if (free_q) begin
              sum_d   = sum_q + SUM_W'(val_q);
              count_d = count_q + CNT_W'(1);
              op_d    = OP_NEW;
              tgt_d   = free_idx_q;
              state_d = S_APPLY;
            end else begin
              res_status_d = ST_FULL;
            end
          end
          ACT_RELEASE: begin
            if (hit_q) begin
              count_d     = count_q - CNT_W'(1);
              sum_d       = (count_d == '0) ? '0 : sum_q - SUM_W'(hit_val_q);
              res_found_d = 1'b1;
              op_d        = OP_KILL;
              tgt_d       = hit_idx_q;
              state_d     = S_APPLY;
            end else begin
              res_status_d = ST_ABSENT;
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (min_q) begin
              res_found_d = 1'b1;
              res_key_d   = min_key_q;
              res_val_d   = min_val_q;
              if (act_q == ACT_POP) begin
                count_d = count_q - CNT_W'(1);
                sum_d   = (count_d == '0) ? '0 : sum_q - SUM_W'(min_val_q);
                op_d    = OP_KILL;
                tgt_d   = min_idx_q;
                state_d = S_APPLY;
              end
            end else begin
              res_status_d = ST_ABSENT;
            end
          end
          ACT_CONTAINS: begin
            if (hit_q) res_found_d = 1'b1;
            else       res_status_d = ST_ABSENT;
          end
          default: ;
        endcase
      end
      S_APPLY: begin
        if (last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q        <= tgt_d;
    op_q         <= op_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;

    if (accept) begin
      act_q  <= in_data_i.action;
      key_q  <= in_data_i.entry_key;
      val_q  <= in_data_i.entry_value;
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      min_q  <= 1'b0;
    end else if (cell_ctl.shift) begin
      cnt_q <= last ? '0 : cnt_q + IDX_W'(1);
      if (state_q == S_SCAN) begin
        // first match and first free slot win; strict compare keeps lowest slot on ties
        if (!hit_q && tail.valid && tail.key == key_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cnt_q;
          hit_val_q <= tail.value;
        end
        if (!free_q && !tail.valid) begin
          free_q     <= 1'b1;
          free_idx_q <= cnt_q;
        end
        if (tail.valid && (!min_q || tail.value < min_val_q)) begin
          min_q     <= 1'b1;
          min_idx_q <= cnt_q;
          min_key_q <= tail.key;
          min_val_q <= tail.value;
        end
      end
    end

    if (state_q == S_EMIT && out_free) begin
      out_data_q.status     <= res_status_q;
      out_data_q.found      <= res_found_q;
      out_data_q.out_key    <= res_key_q;
      out_data_q.out_value  <= res_val_q;
      out_data_q.total_cost <= sum_q;
      out_data_q.live_count <= count_ext[LIVE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/kmpt_checker.sv */
// Port-level checks for keyed_min_priority_table, attached with bind.
// Depends on kmpt_pkg.
`timescale 1ns / 1ps

module kmpt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input kmpt_pkg::rsp_t out_data_o
);
  import kmpt_pkg::*;

  // the table works on one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transaction");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ENTRIES < 128) |-> (out_data_o.live_count <= ENTRIES))
    else $error("live count above table size");

  a_empty_no_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ENTRIES < 128 && out_data_o.live_count == '0)
      |-> (out_data_o.total_cost == '0))
    else $error("cost left over in an empty table");

  a_no_entry_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found)
      |-> (out_data_o.out_key == '0 && out_data_o.out_value == '0))
    else $error("entry returned without found");

  a_error_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> !out_data_o.found)
    else $error("found set with an error status");

endmodule

bind keyed_min_priority_table kmpt_checker u_kmpt_checker (.*);
